### src/bb_pkg.sv
// shared types, constants and the reciprocal table of the box blur
package bb_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int HALF_MAX = MAX_KERNEL / 2;
  localparam int WIN = 2 * HALF_MAX + 1;
  localparam int SIZE_W = 3;
  localparam int HALF_W = 2;
  localparam int CSUM_W = $clog2(WIN * 255 + 1);
  localparam int SUM_W = $clog2(WIN * WIN * 255 + 1);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int NSQ_W = 2 * SIZE_W;

  localparam logic [1:0] REG_KERNEL_SIZE = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef pixel_t [WIN-1:0] column_t;
  typedef pixel_t [WIN-2:0] stack_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  typedef struct packed {
    logic shift;
    logic col_ok;
    logic [WIN-1:0] row_ok;
  } cell_ctl_t;

  // floor(2^16 / (size*size))
  function automatic logic [RECIP_W-1:0] recip(input logic [SIZE_W-1:0] size);
    logic [RECIP_W-1:0] r;
    case (size)
      3'd2: r = 17'd16384;
      3'd3: r = 17'd7281;
      3'd4: r = 17'd4096;
      3'd5: r = 17'd2621;
      3'd6: r = 17'd1820;
      3'd7: r = 17'd1337;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

### src/bb_ram.sv
// generic single write port ram with registered read
module bb_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/bb_cell.sv
// one window column: holds a vertical stack of pixels and its masked sum
module bb_cell (
  input  logic              clk,
  input  bb_pkg::cell_ctl_t ctl,
  input  bb_pkg::column_t   col_in,
  output bb_pkg::column_t   col_out,
  output bb_pkg::csum_t     sum
);

  bb_pkg::csum_t sum_next;

  always_comb begin
    sum_next = '0;
    for (int m = 0; m < bb_pkg::WIN; m++) begin
      if (ctl.col_ok && ctl.row_ok[m]) begin
        sum_next.red   = sum_next.red + bb_pkg::CSUM_W'(col_out[m].red);
        sum_next.green = sum_next.green + bb_pkg::CSUM_W'(col_out[m].green);
        sum_next.blue  = sum_next.blue + bb_pkg::CSUM_W'(col_out[m].blue);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_out <= col_in;
    end
    sum <= sum_next;
  end

endmodule

### src/bb_div.sv
// divide of the window sums by size*size through a reciprocal, two stages
module bb_div (
  input  logic                        clk,
  input  logic [bb_pkg::SIZE_W-1:0]   size,
  input  bb_pkg::sum_t                total,
  output bb_pkg::pixel_t              mean
);

  logic [bb_pkg::PROD_W-1:0] prod_r, prod_g, prod_b;
  bb_pkg::sum_t              total_d;
  logic [bb_pkg::NSQ_W-1:0]  nsq;

  function automatic logic [7:0] fix(input logic [bb_pkg::PROD_W-1:0] prod,
                                     input logic [bb_pkg::SUM_W-1:0] s,
                                     input logic [bb_pkg::NSQ_W-1:0] n);
    logic [bb_pkg::SUM_W-1:0] q;
    logic [bb_pkg::SUM_W-1:0] rem;
    q = bb_pkg::SUM_W'(prod >> bb_pkg::RECIP_SHIFT);
    rem = s - bb_pkg::SUM_W'(q * bb_pkg::SUM_W'(n));
    if (rem >= bb_pkg::SUM_W'(n)) begin
      q = q + 1'b1;
    end
    return q[7:0];
  endfunction

  always_ff @(posedge clk) begin
    prod_r  <= bb_pkg::PROD_W'(total.red) * bb_pkg::PROD_W'(bb_pkg::recip(size));
    prod_g  <= bb_pkg::PROD_W'(total.green) * bb_pkg::PROD_W'(bb_pkg::recip(size));
    prod_b  <= bb_pkg::PROD_W'(total.blue) * bb_pkg::PROD_W'(bb_pkg::recip(size));
    total_d <= total;
    nsq     <= bb_pkg::NSQ_W'(size) * bb_pkg::NSQ_W'(size);
    mean.red   <= fix(prod_r, total_d.red, nsq);
    mean.green <= fix(prod_g, total_d.green, nsq);
    mean.blue  <= fix(prod_b, total_d.blue, nsq);
  end

endmodule

### src/box_blur_filter_top.sv
// box blur top: position control, column store, window cells and divider
//
//  channel   handshake            payload
//  input     in_valid/in_ready    in_red, in_green, in_blue, frame_start
//  result    res_valid/res_ready  out_valid, out_red, out_green, out_blue, frame_end
//  config    cfg_we               cfg_index, cfg_data
//
// a request passes the load, sum, total, mul and fix states to the result; with no
// pixel due it goes from load to the result, after the frame is done straight there;
// en route: column store read-modify-write, cell column sums, sum tree, two divider
// stages; one request is in flight; a stalled result holds until res_ready
// synchronous reset; no clearing pass, unwritten column store entries are masked out
module box_blur_filter_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        frame_start,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int WIN = bb_pkg::WIN;
  localparam int SW = bb_pkg::SIZE_W;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = $clog2(bb_pkg::HALF_MAX * MAX_WIDTH + bb_pkg::HALF_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SUM, ST_TOTAL, ST_MUL, ST_FIX, ST_OUT
  } state_t;

  state_t state;

  logic [SW-1:0] kernel_size;
  logic [10:0]   frame_width;
  logic [10:0]   frame_height;

  logic [SW-1:0] act_size;
  logic [WW-1:0] act_w;
  logic [HW-1:0] act_h;
  logic [DW-1:0] act_d;
  logic          started;
  logic          fill_done;
  logic [CW-1:0] col;
  logic [DW-1:0] lead;
  logic [CW-1:0] ccol;
  logic [RW-1:0] crow;

  logic [SW-1:0] cfg_size;
  logic [WW-1:0] cfg_w;
  logic [HW-1:0] cfg_h;
  logic [DW-1:0] cfg_d;

  logic          start, accept;
  logic [SW-1:0] e_size;
  logic [bb_pkg::HALF_W-1:0] e_half;
  logic [WW-1:0] e_w;
  logic [HW-1:0] e_h;
  logic [DW-1:0] e_d;
  logic [CW-1:0] e_col;
  logic [DW-1:0] e_lead;
  logic [CW-1:0] e_ccol;
  logic [RW-1:0] e_crow;
  logic          e_fill, due, last;
  logic [WIN-1:0] col_ok_next, row_ok_next;

  logic          fill_done_next;
  logic [CW-1:0] col_next;
  logic [DW-1:0] lead_next;
  logic [CW-1:0] ccol_next;
  logic [RW-1:0] crow_next;

  bb_pkg::pixel_t item_pix;
  logic [CW-1:0]  item_addr;
  logic           item_valid, item_end;
  logic [WIN-1:0] item_col_ok, item_row_ok;

  logic [$bits(bb_pkg::stack_t)-1:0] rd_data;
  bb_pkg::stack_t  stack;
  bb_pkg::column_t col_new;
  bb_pkg::column_t chain [WIN];
  bb_pkg::csum_t   csum [WIN];
  bb_pkg::sum_t    total;
  bb_pkg::pixel_t  mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= 3'd5;
      frame_width  <= 11'd800;
      frame_height <= 11'd600;
    end else if (cfg_we) begin
      case (cfg_index)
        bb_pkg::REG_KERNEL_SIZE: kernel_size <= cfg_data[SW-1:0];
        bb_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data;
        bb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (kernel_size == '0) begin
      cfg_size = SW'(1);
    end else if (32'(kernel_size) > bb_pkg::MAX_KERNEL) begin
      cfg_size = SW'(bb_pkg::MAX_KERNEL);
    end else begin
      cfg_size = kernel_size;
    end
    if (frame_width == '0) begin
      cfg_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      cfg_w = WW'(MAX_WIDTH);
    end else begin
      cfg_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      cfg_h = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      cfg_h = HW'(MAX_HEIGHT);
    end else begin
      cfg_h = HW'(frame_height);
    end
    cfg_d = DW'(32'(cfg_size[SW-1:1]) * 32'(cfg_w) + 32'(cfg_size[SW-1:1]));
  end

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign start = frame_start || !started;

  always_comb begin
    e_size = start ? cfg_size : act_size;
    e_half = e_size[SW-1:1];
    e_w    = start ? cfg_w : act_w;
    e_h    = start ? cfg_h : act_h;
    e_d    = start ? cfg_d : act_d;
    e_col  = start ? '0 : col;
    e_lead = start ? '0 : lead;
    e_ccol = start ? '0 : ccol;
    e_crow = start ? '0 : crow;
    e_fill = start ? 1'b0 : fill_done;
    due  = (e_lead == e_d);
    last = due && (32'(e_ccol) + 1 == 32'(e_w)) && (32'(e_crow) + 1 == 32'(e_h));
  end

  // window column k sits k pixels back, stack row m sits m rows back
  always_comb begin
    int kmin, kmax, sx, sy;
    kmin = 2 * int'(e_half) + 1 - int'(e_size);
    kmax = 2 * int'(e_half);
    for (int k = 0; k < WIN; k++) begin
      sx = int'(e_ccol) + int'(e_half) - k;
      col_ok_next[k] = (k >= kmin) && (k <= kmax) && (sx >= 0) && (sx < int'(e_w));
      sy = int'(e_crow) + int'(e_half) - k;
      row_ok_next[k] = (k >= kmin) && (k <= kmax) && (sy >= 0) && (sy < int'(e_h));
    end
  end

  always_comb begin
    fill_done_next = e_fill;
    col_next  = e_col;
    lead_next = e_lead;
    ccol_next = e_ccol;
    crow_next = e_crow;
    if (!e_fill) begin
      if (last) begin
        fill_done_next = 1'b1;
      end else begin
        if (32'(e_col) + 1 >= 32'(e_w)) begin
          col_next = '0;
        end else begin
          col_next = e_col + 1'b1;
        end
        if (!due) begin
          lead_next = e_lead + 1'b1;
        end else if (32'(e_ccol) + 1 >= 32'(e_w)) begin
          ccol_next = '0;
          crow_next = e_crow + 1'b1;
        end else begin
          ccol_next = e_ccol + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      fill_done <= 1'b0;
      col       <= '0;
      lead      <= '0;
      ccol      <= '0;
      crow      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            started   <= 1'b1;
            act_size  <= e_size;
            act_w     <= e_w;
            act_h     <= e_h;
            act_d     <= e_d;
            fill_done <= fill_done_next;
            col       <= col_next;
            lead      <= lead_next;
            ccol      <= ccol_next;
            crow      <= crow_next;
            item_pix    <= '{red: in_red, green: in_green, blue: in_blue};
            item_addr   <= e_col;
            item_valid  <= !e_fill && due;
            item_end    <= !e_fill && last;
            item_col_ok <= col_ok_next;
            item_row_ok <= row_ok_next;
            state <= e_fill ? ST_OUT : ST_LOAD;
          end
        end
        ST_LOAD: state <= item_valid ? ST_SUM : ST_OUT;
        ST_SUM: state <= ST_TOTAL;
        ST_TOTAL: state <= ST_MUL;
        ST_MUL: state <= ST_FIX;
        ST_FIX: state <= ST_OUT;
        ST_OUT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bb_ram #(
    .WIDTH($bits(bb_pkg::stack_t)),
    .DEPTH(MAX_WIDTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (state == ST_LOAD),
    .wr_addr(item_addr),
    .wr_data(col_new[WIN-2:0]),
    .rd_en  (accept),
    .rd_addr(e_col),
    .rd_data(rd_data)
  );

  assign stack = rd_data;

  always_comb begin
    col_new[0] = item_pix;
    for (int m = 1; m < WIN; m++) begin
      col_new[m] = stack[m-1];
    end
  end

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    bb_pkg::cell_ctl_t ctl;
    assign ctl = '{shift: (state == ST_LOAD), col_ok: item_col_ok[k], row_ok: item_row_ok};
    bb_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .col_in ((k == 0) ? col_new : chain[(k == 0) ? 0 : k - 1]),
      .col_out(chain[k]),
      .sum    (csum[k])
    );
  end

  always_ff @(posedge clk) begin
    bb_pkg::sum_t acc;
    acc = '0;
    for (int k = 0; k < WIN; k++) begin
      acc.red   = acc.red + bb_pkg::SUM_W'(csum[k].red);
      acc.green = acc.green + bb_pkg::SUM_W'(csum[k].green);
      acc.blue  = acc.blue + bb_pkg::SUM_W'(csum[k].blue);
    end
    total <= acc;
  end

  bb_div u_div (
    .clk  (clk),
    .size (act_size),
    .total(total),
    .mean (mean)
  );

  assign res_valid = (state == ST_OUT);
  assign out_valid = item_valid;
  assign out_red   = item_valid ? mean.red : 8'd0;
  assign out_green = item_valid ? mean.green : 8'd0;
  assign out_blue  = item_valid ? mean.blue : 8'd0;
  assign frame_end = item_end;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && res_valid))
    else $error("request accepted while a result is pending");

  a_end_is_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_end |-> out_valid)
    else $error("frame end on an empty result");

  a_load_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> $past(accept))
    else $error("column store update without a request");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !start && fill_done |=> res_valid && !out_valid)
    else $error("pixel processed after frame end");

endmodule
